// ===== rtl/core/fdmm_pkg.sv =====
// shared types, constants and helper functions for the frame difference motion mask core
package fdmm_pkg;

  // configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TINT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd3;

  // register reset values
  localparam logic [7:0]  DIFF_THR_RST = 8'd31;
  localparam logic [7:0]  LUMA_THR_RST = 8'd95;
  localparam logic [23:0] TINT_RST     = 24'h00FF00;
  localparam logic [1:0]  MODE_RST     = 2'd3;

  // effect mode bits: bit 0 selects hard alpha, bit 1 selects tint color
  localparam int MODE_HARD_BIT  = 0;
  localparam int MODE_COLOR_BIT = 1;
  localparam logic [7:0] ALPHA_FULL = 8'd255;

  // floor(x / 3) = (x * ceil(2^19 / 3)) >> 19, exact for x below 2^19
  localparam logic [17:0] DIV3_MUL   = 18'd174763;
  localparam int          DIV3_SHIFT = 19;

  // pipeline depth of the square root unit
  localparam int SQRT_STG = 4;

  // side data that rides along with each pixel
  typedef struct packed {
    logic [23:0] cur;
    logic        luma_ok;
  } side_t;

  // one digit step of the restoring square root
  typedef struct packed {
    logic [8:0] rem;
    logic [7:0] root;
  } sqrt_st_t;

  function automatic sqrt_st_t sqrt_step(input sqrt_st_t st, input logic [1:0] pair);
    logic [10:0] rem_sh;
    logic [10:0] trial;
    sqrt_st_t    res;
    rem_sh = {st.rem, pair};
    trial  = {1'b0, st.root, 2'b01};
    if (rem_sh >= trial) begin
      res.rem  = 9'(rem_sh - trial);
      res.root = {st.root[6:0], 1'b1};
    end else begin
      res.rem  = rem_sh[8:0];
      res.root = {st.root[6:0], 1'b0};
    end
    return res;
  endfunction

  // absolute difference of two channels
  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? 8'(a - b) : 8'(b - a);
  endfunction

endpackage

// ===== rtl/core/fdmm_stream_if.sv =====
// valid/ready stream interfaces for the pixel pair input and the mask result
interface fdmm_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] prev_pixel;
  logic [23:0] cur_pixel;

  modport source (output valid, output prev_pixel, output cur_pixel, input ready);
  modport sink   (input valid, input prev_pixel, input cur_pixel, output ready);
endinterface

interface fdmm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_alpha, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input out_alpha, output ready);
endinterface

// ===== rtl/core/fdmm_isqrt_pipe.sv =====
// pipelined 16-bit integer square root, two result bits per stage
module fdmm_isqrt_pipe import fdmm_pkg::*; (
  input  logic                clk,
  input  logic [SQRT_STG-1:0] stg_en,
  input  logic [15:0]         val_in,
  output logic [7:0]          root_out
);

  sqrt_st_t    st_r  [SQRT_STG];
  logic [15:0] val_r [SQRT_STG];

  for (genvar j = 0; j < SQRT_STG; j++) begin : g_stg
    localparam int P_HI = 7 - 2 * j;
    localparam int P_LO = 6 - 2 * j;
    sqrt_st_t    st_in;
    logic [15:0] v_in;
    sqrt_st_t    st_mid;
    sqrt_st_t    st_nxt;

    // stage input: first stage starts from zero
    if (j == 0) begin : g_first
      assign st_in = '0;
      assign v_in  = val_in;
    end else begin : g_rest
      assign st_in = st_r[j-1];
      assign v_in  = val_r[j-1];
    end

    // two digit steps per stage
    always_comb begin
      st_mid = sqrt_step(st_in, v_in[2*P_HI+1 -: 2]);
      st_nxt = sqrt_step(st_mid, v_in[2*P_LO+1 -: 2]);
    end

    always_ff @(posedge clk) begin
      if (stg_en[j]) begin
        st_r[j]  <= st_nxt;
        val_r[j] <= v_in;
      end
    end
  end

  assign root_out = st_r[SQRT_STG-1].root;

endmodule

// ===== rtl/core/frame_diff_motion_mask_core.sv =====
// top level of the frame difference motion mask core
//
//   channel   dir  handshake        payload
//   in_ch     in   valid / ready    prev_pixel[23:0], cur_pixel[23:0]
//   out_ch    out  valid / ready    out_red, out_green, out_blue, out_alpha [7:0]
//   cfg_*     in   cfg_we only      cfg_index[2:0], cfg_wdata[23:0]
//
// one beat per clock sustained while out_ch.ready stays high, through a nine-stage pipeline
// (difference, squares, sum, divide by three, four square root stages, output)
// each stage holds its beat while the next is full and stalled; empty stages fill
// so bubbles collapse and in_ch.ready follows out_ch.ready through the chain
// rst_n is synchronous, clears the valid bits and loads the register defaults
module frame_diff_motion_mask_core import fdmm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  fdmm_in_if.sink               in_ch,
  fdmm_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NS       = 9;
  localparam int S_DIFF   = 0;
  localparam int S_SQ     = 1;
  localparam int S_SUM    = 2;
  localparam int S_DIV    = 3;
  localparam int S_ROOT0  = 4;
  localparam int S_OUT    = S_ROOT0 + SQRT_STG;

  // configuration registers
  logic [7:0]  diff_thr_r;
  logic [7:0]  luma_thr_r;
  logic [23:0] tint_r;
  logic [1:0]  mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_thr_r <= DIFF_THR_RST;
      luma_thr_r <= LUMA_THR_RST;
      tint_r     <= TINT_RST;
      mode_r     <= MODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIFF_THR: diff_thr_r <= cfg_wdata[7:0];
        REG_LUMA_THR: luma_thr_r <= cfg_wdata[7:0];
        REG_TINT:     tint_r     <= cfg_wdata[23:0];
        REG_MODE:     mode_r     <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and advance chain
  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !v_r[NS-1] || out_ch.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    for (int i = 0; i < NS; i++) begin
      if (adv[i]) begin
        v_nxt[i] = (i == 0) ? in_ch.valid : v_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready = adv[0];

  // side data carried beside the arithmetic
  side_t side_r [S_OUT];
  side_t side_nxt;
  logic [12:0] gray_sum;
  logic [7:0]  gray;

  always_comb begin
    gray_sum = 13'd11 * 13'(in_ch.cur_pixel[23:16])
             + 13'd16 * 13'(in_ch.cur_pixel[15:8])
             + 13'd5  * 13'(in_ch.cur_pixel[7:0]);
    gray     = gray_sum[12:5];
    side_nxt.cur     = in_ch.cur_pixel;
    side_nxt.luma_ok = !(gray < luma_thr_r);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      side_r[0] <= side_nxt;
    end
  end

  for (genvar i = 1; i < S_OUT; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv[i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // stage 0: channel differences
  logic [7:0] dr_r, dg_r, db_r;

  always_ff @(posedge clk) begin
    if (adv[S_DIFF]) begin
      dr_r <= abs_diff(in_ch.prev_pixel[23:16], in_ch.cur_pixel[23:16]);
      dg_r <= abs_diff(in_ch.prev_pixel[15:8],  in_ch.cur_pixel[15:8]);
      db_r <= abs_diff(in_ch.prev_pixel[7:0],   in_ch.cur_pixel[7:0]);
    end
  end

  // stage 1: squares
  logic [15:0] sr_r, sg_r, sb_r;

  always_ff @(posedge clk) begin
    if (adv[S_SQ]) begin
      sr_r <= 16'(dr_r) * 16'(dr_r);
      sg_r <= 16'(dg_r) * 16'(dg_r);
      sb_r <= 16'(db_r) * 16'(db_r);
    end
  end

  // stage 2: sum of squares
  logic [17:0] sum_r;

  always_ff @(posedge clk) begin
    if (adv[S_SUM]) begin
      sum_r <= 18'(sr_r) + 18'(sg_r) + 18'(sb_r);
    end
  end

  // stage 3: divide by three through the reciprocal
  logic [35:0] div_prod;
  logic [15:0] quot_r;

  assign div_prod = 36'(sum_r) * 36'(DIV3_MUL);

  always_ff @(posedge clk) begin
    if (adv[S_DIV]) begin
      quot_r <= div_prod[DIV3_SHIFT+15:DIV3_SHIFT];
    end
  end

  // stages 4 to 7: square root
  logic [7:0] rms;

  fdmm_isqrt_pipe u_isqrt (
    .clk      (clk),
    .stg_en   (adv[S_OUT-1:S_ROOT0]),
    .val_in   (quot_r),
    .root_out (rms)
  );

  // stage 8: alpha decision and color select
  side_t      side_last;
  logic [7:0] alpha_nxt;
  logic [23:0] rgb_nxt;
  logic [7:0] alpha_r;
  logic [23:0] rgb_r;

  assign side_last = side_r[S_OUT-1];

  always_comb begin
    if (!side_last.luma_ok || rms < diff_thr_r) begin
      alpha_nxt = '0;
    end else if (mode_r[MODE_HARD_BIT]) begin
      alpha_nxt = ALPHA_FULL;
    end else begin
      alpha_nxt = rms;
    end
    rgb_nxt = mode_r[MODE_COLOR_BIT] ? tint_r : side_last.cur;
  end

  always_ff @(posedge clk) begin
    if (adv[S_OUT]) begin
      alpha_r <= alpha_nxt;
      rgb_r   <= rgb_nxt;
    end
  end

  assign out_ch.valid     = v_r[S_OUT];
  assign out_ch.out_red   = rgb_r[23:16];
  assign out_ch.out_green = rgb_r[15:8];
  assign out_ch.out_blue  = rgb_r[7:0];
  assign out_ch.out_alpha = alpha_r;

  // a refused input beat means the first stage is full
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> v_r[S_DIFF])
    else $error("input refused while first stage is empty");

  // an accepted beat occupies the first stage next cycle
  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v_r[S_DIFF])
    else $error("accepted beat did not enter the pipeline");

  // hard modes give only zero or full alpha
  a_hard_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && mode_r[MODE_HARD_BIT] && out_ch.out_alpha != 8'd0
      |-> out_ch.out_alpha == ALPHA_FULL)
    else $error("hard mode alpha is neither zero nor full");

  // soft mode alpha never falls below the difference threshold unless zero
  a_soft_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !mode_r[MODE_HARD_BIT] && out_ch.out_alpha != 8'd0
      |-> out_ch.out_alpha >= diff_thr_r)
    else $error("soft mode alpha below difference threshold");

  // a stalled output stage keeps its beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(alpha_r) && $stable(rgb_r))
    else $error("stalled result beat changed");

endmodule
